/* src/wbg_pkg.sv */
// Shared constants, lane codes and elaboration-time helper functions for the
// white balance gain unit. No dependencies.
package wbg_pkg;

  // Payload widths.
  localparam int unsigned EXPO_W = 24;
  localparam int unsigned TEMP_W = 14;
  localparam int unsigned TINT_W = 17;
  localparam int unsigned GAIN_W = 24;

  // Internal widths.
  localparam int unsigned LOG_W   = 20;  // log2(T) in Q16, integer part 4 bits
  localparam int unsigned S_W     = 24;  // temperature stops in Q20
  localparam int unsigned OFF_W   = 18;  // tint offset in Q20
  localparam int unsigned PROD_W  = 42;  // stops times Q16 coefficient
  localparam int unsigned EXP_W   = 26;  // exp2 argument in Q20
  localparam int unsigned G_W     = 32;  // channel gain in Q24
  localparam int unsigned LUMP_W  = 48;  // gain times luma weight
  localparam int unsigned LUM_W   = 34;  // luminance in Q24
  localparam int unsigned Q_W     = 29;  // gain ratio in Q24
  localparam int unsigned OUTP_W  = EXPO_W + Q_W;

  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned EXP_STEPS = 20;
  localparam int unsigned LANES     = 3;

  // Lane codes.
  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;

  // Fixed-point constants.
  localparam logic [TEMP_W-1:0]        TEMP_MIN      = 14'd1000;
  localparam logic [TEMP_W-1:0]        TEMP_MAX      = 14'd15000;
  localparam logic signed [21:0]       LOG2_NEUTRAL  = 22'sd830183;
  localparam logic signed [TINT_W-1:0] TINT_LIMIT    = 17'sd52429;
  localparam logic signed [OFF_W-1:0]  TINT_NEUTRAL  = 18'sd3417;
  localparam logic signed [PROD_W-1:0] RED_COEF      = 42'sd7864;
  localparam logic signed [PROD_W-1:0] BLUE_COOL     = 42'sd81920;
  localparam logic signed [PROD_W-1:0] BLUE_WARM     = 42'sd39322;
  localparam logic [15:0]              LUMA_R        = 16'd13933;
  localparam logic [15:0]              LUMA_G        = 16'd46871;
  localparam logic [15:0]              LUMA_B        = 16'd4732;
  localparam logic [GAIN_W-1:0]        OUT_MAX       = 24'hFFFFFF;

  // Integer square root, bit by bit; only evaluated at elaboration.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] rem;
    r   = '0;
    bt  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Roots 2^(2^-i) in Q30 for i = 1..EXP_STEPS, each from the previous one.
  function automatic logic [EXP_STEPS:1][31:0] root_table();
    logic [EXP_STEPS:1][31:0] t;
    logic [63:0]              root;
    root = 64'd1 << 31;
    for (int i = 1; i <= EXP_STEPS; i++) begin
      root = isqrt64(root << 30);
      t[i] = root[31:0];
    end
    return t;
  endfunction

  localparam logic [EXP_STEPS:1][31:0] EXP_ROOTS = root_table();

endpackage

/* src/wbg_if.sv */
// Handshake interfaces for the request and result channels of the white
// balance gain unit. Depends on wbg_pkg.
interface wbg_in_if import wbg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [EXPO_W-1:0]        exposure;
  logic [TEMP_W-1:0]        temperature_kelvin;
  logic signed [TINT_W-1:0] tint;

  modport source (output valid, exposure, temperature_kelvin, tint, input ready);
  modport sink   (input valid, exposure, temperature_kelvin, tint, output ready);
endinterface

interface wbg_out_if import wbg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain_red;
  logic [GAIN_W-1:0] gain_green;
  logic [GAIN_W-1:0] gain_blue;

  modport source (output valid, gain_red, gain_green, gain_blue, input ready);
  modport sink   (input valid, gain_red, gain_green, gain_blue, output ready);
endinterface

/* src/wbg_log2.sv */
// Pipelined log2 of a clamped temperature: normalize, then one square and
// compare per stage. Depends on wbg_pkg.
module wbg_log2 import wbg_pkg::*; #(
  parameter int unsigned TAG_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              v_i,
  input  logic [TEMP_W-1:0] temp_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              v_o,
  output logic [LOG_W-1:0]  log_o,
  output logic [TAG_W-1:0]  tag_o
);

  logic [LOG_STEPS:0]  v_q;
  logic [30:0]         x_q   [0:LOG_STEPS];
  logic [15:0]         fr_q  [0:LOG_STEPS];
  logic [3:0]          e_q   [0:LOG_STEPS];
  logic [TAG_W-1:0]    tag_q [0:LOG_STEPS];

  logic [3:0]  e0;
  logic [4:0]  sh0;
  logic [30:0] x0;
  logic [30:0] x_d  [1:LOG_STEPS];
  logic [15:0] fr_d [1:LOG_STEPS];

  // Leading one position and normalization into Q30.
  always_comb begin
    e0 = '0;
    for (int b = 0; b < TEMP_W; b++) begin
      if (temp_i[b]) begin
        e0 = 4'(b);
      end
    end
    sh0 = 5'd30 - 5'(e0);
    x0  = 31'(temp_i) << sh0;
  end

  // One fraction bit per stage.
  always_comb begin
    logic [61:0] sq;
    logic [31:0] y;
    for (int s = 0; s < LOG_STEPS; s++) begin
      sq = 62'(x_q[s]) * 62'(x_q[s]);
      y  = sq[61:30];
      x_d[s+1]  = y[31] ? y[31:1] : y[30:0];
      fr_d[s+1] = {fr_q[s][14:0], y[31]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[LOG_STEPS-1:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]   <= x0;
      fr_q[0]  <= '0;
      e_q[0]   <= e0;
      tag_q[0] <= tag_i;
      for (int s = 0; s < LOG_STEPS; s++) begin
        x_q[s+1]   <= x_d[s+1];
        fr_q[s+1]  <= fr_d[s+1];
        e_q[s+1]   <= e_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign v_o   = v_q[LOG_STEPS];
  assign log_o = {e_q[LOG_STEPS], fr_q[LOG_STEPS]};
  assign tag_o = tag_q[LOG_STEPS];

endmodule

/* src/wbg_exp2.sv */
// Three-lane pipelined exp2 of a signed Q20 exponent into a Q24 gain: one
// constant root product per stage, then a rounding shift. Depends on wbg_pkg.
module wbg_exp2 import wbg_pkg::*; #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    v_i,
  input  logic signed [EXP_W-1:0] e_i [LANES],
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    v_o,
  output logic [G_W-1:0]          g_o [LANES],
  output logic [TAG_W-1:0]        tag_o
);

  localparam int unsigned NST = EXP_STEPS + 2;

  logic [NST-1:0]          v_q;
  logic signed [5:0]       k_q   [0:EXP_STEPS][LANES];
  logic [EXP_STEPS-1:0]    f_q   [0:EXP_STEPS][LANES];
  logic [31:0]             res_q [0:EXP_STEPS][LANES];
  logic [TAG_W-1:0]        tag_q [0:EXP_STEPS+1];
  logic [G_W-1:0]          g_q   [LANES];

  logic [31:0]    res_d [1:EXP_STEPS][LANES];
  logic [G_W-1:0] g_d   [LANES];

  always_comb begin
    logic [63:0] p;
    for (int s = 0; s < EXP_STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        p = 64'(res_q[s][l]) * 64'(EXP_ROOTS[s+1]) + (64'd1 << 29);
        res_d[s+1][l] = f_q[s][l][EXP_STEPS-1-s] ? p[61:30] : res_q[s][l];
      end
    end
  end

  // Scale by 2^k into Q24, rounding half up on a right shift.
  always_comb begin
    logic signed [7:0] sh;
    logic [63:0]       w;
    for (int l = 0; l < LANES; l++) begin
      sh = 8'sd6 - 8'(k_q[EXP_STEPS][l]);
      w  = 64'(res_q[EXP_STEPS][l]);
      if (sh > 8'sd0) begin
        w = (w + (64'd1 << 7'(sh - 8'sd1))) >> 7'(sh);
      end else begin
        w = w << 7'(-sh);
      end
      g_d[l] = w[G_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NST-2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        k_q[0][l]   <= e_i[l][EXP_W-1:EXP_STEPS];
        f_q[0][l]   <= e_i[l][EXP_STEPS-1:0];
        res_q[0][l] <= 32'd1 << 30;
        g_q[l]      <= g_d[l];
      end
      for (int s = 0; s < EXP_STEPS; s++) begin
        tag_q[s+1] <= tag_q[s];
        for (int l = 0; l < LANES; l++) begin
          k_q[s+1][l]   <= k_q[s][l];
          f_q[s+1][l]   <= f_q[s][l];
          res_q[s+1][l] <= res_d[s+1][l];
        end
      end
      tag_q[EXP_STEPS+1] <= tag_q[EXP_STEPS];
    end
  end

  assign v_o   = v_q[NST-1];
  assign g_o   = g_q;
  assign tag_o = tag_q[EXP_STEPS+1];

endmodule

/* src/wbg_div.sv */
// Three-lane pipelined restoring divider: rounded gain over luminance in
// Q24, one quotient bit per stage. Depends on wbg_pkg.
module wbg_div import wbg_pkg::*; #(
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             v_i,
  input  logic [G_W-1:0]   g_i [LANES],
  input  logic [LUM_W-1:0] lum_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [Q_W-1:0]   r_o [LANES],
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned N_W = G_W + 25;

  logic [Q_W:0]       v_q;
  logic [LUM_W-1:0]   rem_q [0:Q_W][LANES];
  logic [Q_W-1:0]     n_q   [0:Q_W][LANES];
  logic [Q_W-1:0]     q_q   [0:Q_W][LANES];
  logic [LUM_W-1:0]   lum_q [0:Q_W];
  logic [TAG_W-1:0]   tag_q [0:Q_W];

  logic [N_W-1:0]   n0   [LANES];
  logic [LUM_W-1:0] rem_d [1:Q_W][LANES];
  logic [Q_W-1:0]   q_d   [1:Q_W][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      n0[l] = {1'b0, g_i[l], 24'd0} + N_W'(lum_i >> 1);
    end
  end

  always_comb begin
    logic [LUM_W:0] t;
    for (int s = 0; s < Q_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem_q[s][l], n_q[s][l][Q_W-1-s]};
        if (t >= (LUM_W+1)'(lum_q[s])) begin
          t = t - (LUM_W+1)'(lum_q[s]);
          q_d[s+1][l] = {q_q[s][l][Q_W-2:0], 1'b1};
        end else begin
          q_d[s+1][l] = {q_q[s][l][Q_W-2:0], 1'b0};
        end
        rem_d[s+1][l] = t[LUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[Q_W-1:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lum_q[0] <= lum_i;
      tag_q[0] <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= LUM_W'(n0[l][N_W-1:Q_W]);
        n_q[0][l]   <= n0[l][Q_W-1:0];
        q_q[0][l]   <= '0;
      end
      for (int s = 0; s < Q_W; s++) begin
        lum_q[s+1] <= lum_q[s];
        tag_q[s+1] <= tag_q[s];
        for (int l = 0; l < LANES; l++) begin
          rem_q[s+1][l] <= rem_d[s+1][l];
          n_q[s+1][l]   <= n_q[s][l];
          q_q[s+1][l]   <= q_d[s+1][l];
        end
      end
    end
  end

  assign v_o   = v_q[Q_W];
  assign r_o   = q_q[Q_W];
  assign tag_o = tag_q[Q_W];

endmodule

/* src/white_balance_gain_calc.sv */
// White balance gain unit, top level: input clamp, exponent math, luminance,
// output scaling and output buffering. Depends on wbg_pkg, wbg_if, wbg_log2,
// wbg_exp2 and wbg_div.
//
// Usage: a request beat on in_i carries an exposure factor (Q8.16), a
// temperature in kelvin and a signed tint (units of 2^-20). Each request
// yields exactly one result beat on out_o with the red, green and blue gains
// in Q8.16, saturated at the largest code, in request order.
// One request is taken every cycle while in_i.ready is high; the sustained
// rate of one beat per cycle is set by the single pipeline, whose longest
// parts are the 16 log2 squaring stages, the 20 exp2 root stages and the
// 29 divider stages.
// Reset clears every valid bit, so the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its beat and one more
// finished result drops into a skid register; only then does the pipeline
// freeze as a whole and in_i.ready go low, so nothing is lost or repeated.
module white_balance_gain_calc import wbg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  wbg_in_if.sink          in_i,
  wbg_out_if.source       out_o
);

  localparam int unsigned LOG_TAG_W = EXPO_W + TINT_W;

  // The pipeline advances unless the skid register is occupied.
  logic adv;
  logic skid_v_q;
  logic out_v_q;

  assign adv        = !skid_v_q;
  assign in_i.ready = adv;

  // Input stage: clamp temperature and tint.
  logic [TEMP_W-1:0]        temp_c;
  logic signed [TINT_W-1:0] tint_c;

  always_comb begin
    temp_c = in_i.temperature_kelvin;
    if (temp_c < TEMP_MIN) begin
      temp_c = TEMP_MIN;
    end else if (temp_c > TEMP_MAX) begin
      temp_c = TEMP_MAX;
    end
    tint_c = in_i.tint;
    if (tint_c > TINT_LIMIT) begin
      tint_c = TINT_LIMIT;
    end else if (tint_c < -TINT_LIMIT) begin
      tint_c = -TINT_LIMIT;
    end
  end

  logic                     s0_v_q;
  logic [EXPO_W-1:0]        s0_expo_q;
  logic [TEMP_W-1:0]        s0_temp_q;
  logic signed [TINT_W-1:0] s0_tint_q;

  // log2 of the temperature.
  logic                 lg_v;
  logic [LOG_W-1:0]     lg_log;
  logic [LOG_TAG_W-1:0] lg_tag;

  wbg_log2 #(.TAG_W(LOG_TAG_W)) u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .v_i    (s0_v_q),
    .temp_i (s0_temp_q),
    .tag_i  ({s0_expo_q, s0_tint_q}),
    .v_o    (lg_v),
    .log_o  (lg_log),
    .tag_o  (lg_tag)
  );

  // Stage A: stops relative to neutral (Q20) and tint offset.
  logic signed [21:0] s16;
  assign s16 = $signed({2'b00, lg_log}) - LOG2_NEUTRAL;

  logic                    a_v_q;
  logic signed [S_W-1:0]   a_s20_q;
  logic signed [OFF_W-1:0] a_off_q;
  logic [EXPO_W-1:0]       a_expo_q;

  // Stage B: temperature terms before rounding.
  logic                     b_v_q;
  logic signed [PROD_W-1:0] b_pr_q;
  logic signed [PROD_W-1:0] b_pb_q;
  logic signed [OFF_W-1:0]  b_off_q;
  logic [EXPO_W-1:0]        b_expo_q;

  logic signed [PROD_W-1:0] s20x;
  assign s20x = PROD_W'(a_s20_q);

  // Stage C: the three exp2 arguments.
  function automatic logic signed [EXP_W-1:0] rnd16(logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + PROD_W'(32768)) >> 16;
    if (v[PROD_W-1]) begin
      q = -q;
    end
    return EXP_W'(q);
  endfunction

  logic                    c_v_q;
  logic signed [EXP_W-1:0] c_e_q [LANES];
  logic [EXPO_W-1:0]       c_expo_q;

  logic signed [EXP_W-1:0] off3;
  assign off3 = EXP_W'(b_off_q) * EXP_W'(3);

  // exp2 of each exponent.
  logic              ex_v;
  logic [G_W-1:0]    ex_g [LANES];
  logic [EXPO_W-1:0] ex_expo;

  wbg_exp2 #(.TAG_W(EXPO_W)) u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .v_i    (c_v_q),
    .e_i    (c_e_q),
    .tag_i  (c_expo_q),
    .v_o    (ex_v),
    .g_o    (ex_g),
    .tag_o  (ex_expo)
  );

  // Stages L1 and L2: Rec.709 luminance of the three gains.
  logic              l1_v_q;
  logic [LUMP_W-1:0] l1_p_q [LANES];
  logic [G_W-1:0]    l1_g_q [LANES];
  logic [EXPO_W-1:0] l1_expo_q;

  logic              l2_v_q;
  logic [G_W-1:0]    l2_g_q [LANES];
  logic [LUM_W-1:0]  l2_lum_q;
  logic [EXPO_W-1:0] l2_expo_q;

  logic [LUMP_W+1:0] lsum;
  logic [LUM_W-1:0]  lum_d;
  always_comb begin
    lsum  = (LUMP_W+2)'(l1_p_q[LANE_R]) + (LUMP_W+2)'(l1_p_q[LANE_G])
          + (LUMP_W+2)'(l1_p_q[LANE_B]) + (LUMP_W+2)'(32768);
    lum_d = lsum[LUMP_W+1:16];
    if (lum_d == '0) begin
      lum_d = LUM_W'(1);
    end
  end

  // Gain over luminance.
  logic              dv_v;
  logic [Q_W-1:0]    dv_r [LANES];
  logic [EXPO_W-1:0] dv_expo;

  wbg_div #(.TAG_W(EXPO_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .v_i    (l2_v_q),
    .g_i    (l2_g_q),
    .lum_i  (l2_lum_q),
    .tag_i  (l2_expo_q),
    .v_o    (dv_v),
    .r_o    (dv_r),
    .tag_o  (dv_expo)
  );

  // Stage M: exposure times ratio; rounding and saturation follow.
  logic              m_v_q;
  logic [OUTP_W-1:0] m_p_q [LANES];
  logic [GAIN_W-1:0] sat [LANES];

  always_comb begin
    logic [OUTP_W:0] t;
    for (int l = 0; l < LANES; l++) begin
      t      = (OUTP_W+1)'(m_p_q[l]) + ((OUTP_W+1)'(1) << 23);
      sat[l] = (t[OUTP_W:24] > (OUTP_W-23)'(OUT_MAX)) ? OUT_MAX : t[47:24];
    end
  end

  // Output register and skid register.
  logic              out_take;
  logic [GAIN_W-1:0] out_q  [LANES];
  logic [GAIN_W-1:0] skid_q [LANES];

  assign out_take = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      a_v_q    <= 1'b0;
      b_v_q    <= 1'b0;
      c_v_q    <= 1'b0;
      l1_v_q   <= 1'b0;
      l2_v_q   <= 1'b0;
      m_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        s0_v_q <= in_i.valid;
        a_v_q  <= lg_v;
        b_v_q  <= a_v_q;
        c_v_q  <= b_v_q;
        l1_v_q <= ex_v;
        l2_v_q <= l1_v_q;
        m_v_q  <= dv_v;
      end
      if (out_take) begin
        out_v_q  <= skid_v_q || m_v_q;
        skid_v_q <= 1'b0;
      end else if (m_v_q && adv) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_expo_q <= in_i.exposure;
      s0_temp_q <= temp_c;
      s0_tint_q <= tint_c;

      a_s20_q  <= $signed({s16[19:0], 4'b0000});
      a_off_q  <= OFF_W'(signed'(lg_tag[TINT_W-1:0])) - TINT_NEUTRAL;
      a_expo_q <= lg_tag[LOG_TAG_W-1:TINT_W];

      b_pr_q   <= s20x * RED_COEF;
      b_pb_q   <= (-s20x) * (a_s20_q[S_W-1] ? BLUE_COOL : BLUE_WARM);
      b_off_q  <= a_off_q;
      b_expo_q <= a_expo_q;

      c_e_q[LANE_R] <= rnd16(b_pr_q) + off3;
      c_e_q[LANE_G] <= -(off3 <<< 1);
      c_e_q[LANE_B] <= rnd16(b_pb_q) + off3;
      c_expo_q      <= b_expo_q;

      l1_p_q[LANE_R] <= LUMP_W'(ex_g[LANE_R]) * LUMP_W'(LUMA_R);
      l1_p_q[LANE_G] <= LUMP_W'(ex_g[LANE_G]) * LUMP_W'(LUMA_G);
      l1_p_q[LANE_B] <= LUMP_W'(ex_g[LANE_B]) * LUMP_W'(LUMA_B);
      l1_g_q         <= ex_g;
      l1_expo_q      <= ex_expo;

      l2_g_q    <= l1_g_q;
      l2_lum_q  <= lum_d;
      l2_expo_q <= l1_expo_q;

      for (int l = 0; l < LANES; l++) begin
        m_p_q[l] <= OUTP_W'(dv_expo) * OUTP_W'(dv_r[l]);
      end
    end
    if (out_take) begin
      out_q <= skid_v_q ? skid_q : sat;
    end else if (adv) begin
      skid_q <= sat;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.gain_red   = out_q[LANE_R];
  assign out_o.gain_green = out_q[LANE_G];
  assign out_o.gain_blue  = out_q[LANE_B];

  // The skid register only holds a beat behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register is empty");

  // The skid register fills only when the output was stalled.
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid register filled without an output stall");

  // A parked beat stays parked while the receiver keeps stalling.
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_o.ready |=> skid_v_q)
    else $error("skid beat dropped during a stall");

endmodule
